@@ hw/rtl/hcrl_pkg.sv @@
// ----------------------------------------------------------------------------
// hcrl_pkg
// types, codes and widths shared by the hair-cell rectify / lowpass block
// ----------------------------------------------------------------------------
package hcrl_pkg;

    localparam int CHANNEL_W = 5;
    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 20;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 20;
    localparam int STATE_W   = 40;
    localparam int STEP_W    = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_A2   = 3'd5;

    // mode register codes
    localparam logic [MODE_W-1:0] MODE_NONE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HALF    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FULL    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SQUARE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOWPASS = 3'd4;

    // multiplier schedule of one lane
    localparam logic [STEP_W-1:0] STEP_B0   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_B1   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_A1   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_B2   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_A2   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_LAST = 3'd5;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_HALF,
        OP_FULL,
        OP_SQUARE,
        OP_LOWPASS
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } coef_t;

    typedef struct packed {
        logic              start;
        logic              run;
        op_t               op;
        logic [STEP_W-1:0] step;
        logic              hist_use;
        logic              hist_wr;
    } lane_ctl_t;

    function automatic op_t mode_to_op(input logic [MODE_W-1:0] mode);
        op_t op;
        unique case (mode)
            MODE_HALF:    op = OP_HALF;
            MODE_FULL:    op = OP_FULL;
            MODE_SQUARE:  op = OP_SQUARE;
            MODE_LOWPASS: op = OP_LOWPASS;
            default:      op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

@@ hw/rtl/hcrl_if.sv @@
// ----------------------------------------------------------------------------
// hcrl_if
// valid / ready channels carrying sample words in and out of the block
// ----------------------------------------------------------------------------
interface hcrl_in_if;
    import hcrl_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CHANNEL_W-1:0]       channel;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;

    modport source (output valid, output channel, output left_in, output right_in,
                    input ready);
    modport sink   (input valid, input channel, input left_in, input right_in,
                    output ready);
endinterface

interface hcrl_out_if;
    import hcrl_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CHANNEL_W-1:0]       channel_out;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;

    modport source (output valid, output channel_out, output left_out,
                    output right_out, input ready);
    modport sink   (input valid, input channel_out, input left_out,
                    input right_out, output ready);
endinterface

@@ hw/rtl/hcrl_lane.sv @@
// ----------------------------------------------------------------------------
// hcrl_lane
// one ear: rectifiers, squarer and biquad on a shared multiplier, own history
// ----------------------------------------------------------------------------
module hcrl_lane #(
    parameter  int CHANNELS = 32,
    localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                                clk,
    input  hcrl_pkg::lane_ctl_t                 ctl,
    input  hcrl_pkg::coef_t                     coef,
    input  logic [ADDR_W-1:0]                   addr,
    input  logic signed [hcrl_pkg::SAMPLE_W-1:0] sample,
    output logic signed [hcrl_pkg::SAMPLE_W-1:0] result
);
    import hcrl_pkg::*;

    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int ACC_W  = STATE_W + 2;

    localparam logic signed [SAMPLE_W-1:0] Q23_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] Q23_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [STATE_W-1:0]  ST_MAX  = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0]  ST_MIN  = {1'b1, {(STATE_W-1){1'b0}}};

    // round to nearest, ties up, dropping 16 or 23 fraction bits
    function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + PROD_W'(32768);
        return ACC_W'(t >>> 16);
    endfunction

    function automatic logic signed [ACC_W-1:0] rnd23(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + PROD_W'(4194304);
        return ACC_W'(t >>> 23);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_q23(input logic signed [ACC_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > ACC_W'(Q23_MAX))
            r = Q23_MAX;
        else if (v < ACC_W'(Q23_MIN))
            r = Q23_MIN;
        else
            r = SAMPLE_W'(v);
        return r;
    endfunction

    function automatic logic signed [STATE_W-1:0] sat_st(input logic signed [ACC_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (v > ACC_W'(ST_MAX))
            r = ST_MAX;
        else if (v < ACC_W'(ST_MIN))
            r = ST_MIN;
        else
            r = STATE_W'(v);
        return r;
    endfunction

    logic [2*STATE_W-1:0]        hist_mem [CHANNELS];
    logic [2*STATE_W-1:0]        mem_q_reg;
    logic signed [SAMPLE_W-1:0]  x_reg;
    logic signed [SAMPLE_W-1:0]  y_reg;
    logic signed [SAMPLE_W-1:0]  res_reg;
    logic signed [STATE_W-1:0]   s1_reg;
    logic signed [STATE_W-1:0]   s2_reg;
    logic signed [STATE_W-1:0]   n1_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [SAMPLE_W-1:0]  mul_a;
    logic signed [SAMPLE_W-1:0]  mul_b;
    logic signed [SAMPLE_W-1:0]  half_x;
    logic signed [SAMPLE_W-1:0]  full_x;
    logic signed [SAMPLE_W-1:0]  simple_res;

    // rectifiers on the incoming sample
    always_comb
    begin
        half_x = sample[SAMPLE_W-1] ? '0 : sample;
        if (sample == Q23_MIN)
            full_x = Q23_MAX;
        else if (sample[SAMPLE_W-1])
            full_x = -sample;
        else
            full_x = sample;
        case (ctl.op)
            OP_HALF: simple_res = half_x;
            OP_FULL: simple_res = full_x;
            default: simple_res = sample;
        endcase
    end

    // multiplier operands by schedule step
    always_comb
    begin
        mul_a = '0;
        mul_b = x_reg;
        case (ctl.step)
            STEP_B0: mul_a = (ctl.op == OP_SQUARE) ? x_reg : SAMPLE_W'($signed(coef.b0));
            STEP_B1: mul_a = SAMPLE_W'($signed(coef.b1));
            STEP_A1:
            begin
                mul_a = SAMPLE_W'($signed(coef.a1));
                mul_b = y_reg;
            end
            STEP_B2: mul_a = SAMPLE_W'($signed(coef.b2));
            STEP_A2:
            begin
                mul_a = SAMPLE_W'($signed(coef.a2));
                mul_b = y_reg;
            end
            default: mul_a = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            mem_q_reg <= hist_mem[addr];
            x_reg     <= (ctl.op == OP_LOWPASS) ? half_x : sample;
            res_reg   <= simple_res;
        end
        if (ctl.run)
        begin
            prod_reg <= mul_a * mul_b;
            case (ctl.step)
                STEP_B0:
                begin
                    s1_reg <= ctl.hist_use ? $signed(mem_q_reg[STATE_W-1:0]) : '0;
                    s2_reg <= ctl.hist_use ? $signed(mem_q_reg[2*STATE_W-1:STATE_W]) : '0;
                end
                STEP_B1:
                begin
                    if (ctl.op == OP_SQUARE)
                        res_reg <= sat_q23(rnd23(prod_reg));
                    else
                        y_reg <= sat_q23(rnd16(prod_reg) + ACC_W'(s1_reg));
                end
                STEP_A1: acc_reg <= rnd16(prod_reg) + ACC_W'(s2_reg);
                STEP_B2: n1_reg  <= sat_st(acc_reg - rnd16(prod_reg));
                STEP_A2: acc_reg <= rnd16(prod_reg);
                STEP_LAST:
                begin
                    res_reg <= y_reg;
                    if (ctl.hist_wr)
                        hist_mem[addr] <= {sat_st(acc_reg - rnd16(prod_reg)), n1_reg};
                end
                default: ;
            endcase
        end
    end

    assign result = res_reg;

endmodule

@@ hw/rtl/hcrl_merge.sv @@
// ----------------------------------------------------------------------------
// hcrl_merge
// output register joining both lanes' results with the channel index
// ----------------------------------------------------------------------------
module hcrl_merge (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic [hcrl_pkg::CHANNEL_W-1:0]       channel,
    input  logic signed [hcrl_pkg::SAMPLE_W-1:0] left,
    input  logic signed [hcrl_pkg::SAMPLE_W-1:0] right,
    output logic                                 free,
    hcrl_out_if.source                           out_word
);
    import hcrl_pkg::*;

    logic                       valid_reg;
    logic                       valid_next;
    logic [CHANNEL_W-1:0]       chan_reg;
    logic signed [SAMPLE_W-1:0] left_reg;
    logic signed [SAMPLE_W-1:0] right_reg;

    // free when empty or being emptied this cycle
    assign free = !valid_reg || out_word.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_word.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chan_reg  <= channel;
            left_reg  <= left;
            right_reg <= right;
        end
    end

    assign out_word.valid       = valid_reg;
    assign out_word.channel_out = chan_reg;
    assign out_word.left_out    = left_reg;
    assign out_word.right_out   = right_reg;

endmodule

@@ hw/rtl/hair_cell_rectify_lowpass_core.sv @@
// ----------------------------------------------------------------------------
// hair_cell_rectify_lowpass_core
// stereo inner-hair-cell envelope stage: pass through, rectify, square or rectify + biquad
// ----------------------------------------------------------------------------
// latency from accept to output valid is spent in ST_RUN (square and
// lowpass modes only), then in ST_LOAD until the output register has room;
// words are taken one at a time, the next only after that load; in lowpass
// mode the five products per ear go through one multiplier per lane
// reset: mode and coefficients cleared, filter history reads as zero, no
// clearing pass; a mode write also restarts every filter
// ----------------------------------------------------------------------------
module hair_cell_rectify_lowpass_core #(
    parameter int CHANNELS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    hcrl_in_if.sink                           in_word,
    hcrl_out_if.source                        out_word,
    input  logic                              cfg_we,
    input  logic [hcrl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hcrl_pkg::CFG_W-1:0]        cfg_wdata
);
    import hcrl_pkg::*;

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // sequencer
    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] last_step;

    // configuration
    logic [MODE_W-1:0] mode_reg;
    coef_t             coef_reg;
    op_t               op;

    // filter history valid bits, one per channel, shared by both ears
    logic [CHANNELS-1:0] hist_valid_reg;

    // per-word context held while the lanes run
    logic [CHANNEL_W-1:0] chan_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic                 keep_reg;
    logic                 use_reg;

    logic        accept;
    logic        load;
    logic        out_free;
    logic [31:0] ch_ext;
    logic        keep_in;
    logic [ADDR_W-1:0] addr_in;
    logic [ADDR_W-1:0] lane_addr;
    lane_ctl_t   lane_ctl;
    logic signed [SAMPLE_W-1:0] left_res;
    logic signed [SAMPLE_W-1:0] right_res;
    logic        mode_wr;

    assign op     = mode_to_op(mode_reg);
    assign accept = in_word.valid && in_word.ready;

    // one word at a time: taken only when the lanes are free
    assign in_word.ready = (state_reg == ST_IDLE);

    // channels at or above the store depth filter from zero and keep nothing
    assign ch_ext  = 32'(in_word.channel);
    assign keep_in = ch_ext < 32'(CHANNELS);
    assign addr_in = ch_ext[ADDR_W-1:0];

    // history read on accept, write back at the end of the lowpass schedule
    assign lane_addr = (state_reg == ST_IDLE) ? addr_in : addr_reg;

    assign last_step = (op == OP_SQUARE) ? STEP_B1 : STEP_LAST;

    assign mode_wr = cfg_we && (cfg_index == REG_MODE);

    always_comb
    begin
        lane_ctl.start    = accept;
        lane_ctl.run      = (state_reg == ST_RUN);
        lane_ctl.op       = op;
        lane_ctl.step     = step_reg;
        lane_ctl.hist_use = use_reg;
        lane_ctl.hist_wr  = (state_reg == ST_RUN) && (op == OP_LOWPASS)
                            && (step_reg == STEP_LAST) && keep_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    step_next = STEP_B0;
                    if ((op == OP_SQUARE) || (op == OP_LOWPASS))
                        state_next = ST_RUN;
                    else
                        state_next = ST_LOAD;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == last_step)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // hand both ears to the output register once it has room
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_B0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // configuration registers; index beyond the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NONE;
            coef_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE: mode_reg    <= cfg_wdata[MODE_W-1:0];
                REG_B0:   coef_reg.b0 <= $signed(cfg_wdata[COEF_W-1:0]);
                REG_B1:   coef_reg.b1 <= $signed(cfg_wdata[COEF_W-1:0]);
                REG_B2:   coef_reg.b2 <= $signed(cfg_wdata[COEF_W-1:0]);
                REG_A1:   coef_reg.a1 <= $signed(cfg_wdata[COEF_W-1:0]);
                REG_A2:   coef_reg.a2 <= $signed(cfg_wdata[COEF_W-1:0]);
                default:  ;
            endcase
        end
    end

    // valid bits stand in for a zeroed store; a mode write restarts all filters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hist_valid_reg <= '0;
        else if (mode_wr)
            hist_valid_reg <= '0;
        else if (lane_ctl.hist_wr)
            hist_valid_reg[addr_reg] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg <= 1'b0;
            use_reg  <= 1'b0;
        end
        else if (accept)
        begin
            keep_reg <= keep_in;
            use_reg  <= keep_in && hist_valid_reg[addr_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            chan_reg <= in_word.channel;
            addr_reg <= addr_in;
        end
    end

    // left and right lanes run the same schedule side by side
    hcrl_lane #(
        .CHANNELS (CHANNELS)
    ) u_lane_left (
        .clk    (clk),
        .ctl    (lane_ctl),
        .coef   (coef_reg),
        .addr   (lane_addr),
        .sample (in_word.left_in),
        .result (left_res)
    );

    hcrl_lane #(
        .CHANNELS (CHANNELS)
    ) u_lane_right (
        .clk    (clk),
        .ctl    (lane_ctl),
        .coef   (coef_reg),
        .addr   (lane_addr),
        .sample (in_word.right_in),
        .result (right_res)
    );

    hcrl_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .channel  (chan_reg),
        .left     (left_res),
        .right    (right_res),
        .free     (out_free),
        .out_word (out_word)
    );

    // history is only ever written for channels inside the store
    a_hist_wr_keep : assert property (@(posedge clk) disable iff (!rst_n)
        lane_ctl.hist_wr |-> keep_reg)
        else $error("history write for channel outside the store");

    // a mode write leaves every filter restarted
    a_mode_clears : assert property (@(posedge clk) disable iff (!rst_n)
        mode_wr |=> (hist_valid_reg == '0))
        else $error("filter history not cleared by mode write");

    // the step counter never runs past the end of the schedule
    a_step_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (step_reg <= STEP_LAST))
        else $error("lane schedule overran");

    // a result is never pushed over one still waiting at the output
    a_load_room : assert property (@(posedge clk) disable iff (!rst_n)
        (load && out_word.valid) |-> out_word.ready)
        else $error("output word overwritten");

endmodule

@@ tb/sv/tb_hair_cell_rectify_lowpass_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hair_cell_rectify_lowpass_core
// self-checking bench for the hair-cell envelope stage: every accepted sample
// word is run through a cycle-free predictor of all five treatments and the
// per-channel biquad history, and every output word is compared field by field
// in order; random bursts on the input, random stalls and one long hold-off on
// the output
// ----------------------------------------------------------------------------
module tb_hair_cell_rectify_lowpass_core;
    import hcrl_pkg::*;

    localparam int N_CHANNELS    = 32;
    localparam int HIST_WORDS    = N_CHANNELS * 4;
    localparam int SETTLE_CYCLES = 16;      // idle time after each drain
    localparam int HOLD_CYCLES   = 300;     // long output hold-off
    localparam int TIMEOUT_NS    = 2_000_000;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
    localparam longint STATE_MAX = 64'sd549755813887;
    localparam longint STATE_MIN = -64'sd549755813888;

    // indexes past the register list, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // unused mode codes, all behave as pass-through
    localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [CHANNEL_W-1:0]       channel;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } sample_word_t;

    // ------------------------------------------------------------------------
    // envelope predictor and in-order result store
    // ------------------------------------------------------------------------
    class envelope_scoreboard;
        sample_word_t      expected_words[$];
        logic [MODE_W-1:0] mode;
        longint            coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
        longint            filter_state[HIST_WORDS];   // s1, s2 per ear per channel
        int                accepted;
        int                checked;
        int                mismatches;

        function new();
            mode       = MODE_NONE;
            coef_b0    = 0;
            coef_b1    = 0;
            coef_b2    = 0;
            coef_a1    = 0;
            coef_a2    = 0;
            accepted   = 0;
            checked    = 0;
            mismatches = 0;
            foreach (filter_state[i])
                filter_state[i] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
            longint c;
            c = longint'($signed(data[COEF_W-1:0]));
            case (index)
                REG_MODE:
                begin
                    // any mode write restarts every filter
                    mode = data[MODE_W-1:0];
                    foreach (filter_state[i])
                        filter_state[i] = 0;
                end
                REG_B0:  coef_b0 = c;
                REG_B1:  coef_b1 = c;
                REG_B2:  coef_b2 = c;
                REG_A1:  coef_a1 = c;
                REG_A2:  coef_a2 = c;
                default: ;
            endcase
        endfunction

        // round to nearest, ties upward, dropping shift fraction bits
        static function longint round_shift(longint v, int shift);
            return (v + (64'sd1 <<< (shift - 1))) >>> shift;
        endfunction

        static function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // transposed direct-form-II biquad, saturated output feeds back
        function longint biquad(longint x, int base, bit keep);
            longint s1, s2, y, n1, n2;
            s1 = keep ? filter_state[base] : 0;
            s2 = keep ? filter_state[base + 1] : 0;
            y  = clamp(round_shift(coef_b0 * x, 16) + s1, SAMPLE_MIN, SAMPLE_MAX);
            n1 = clamp(round_shift(coef_b1 * x, 16) - round_shift(coef_a1 * y, 16) + s2,
                       STATE_MIN, STATE_MAX);
            n2 = clamp(round_shift(coef_b2 * x, 16) - round_shift(coef_a2 * y, 16),
                       STATE_MIN, STATE_MAX);
            if (keep)
            begin
                filter_state[base]     = n1;
                filter_state[base + 1] = n2;
            end
            return y;
        endfunction

        function longint treat(longint x, int base, bit keep);
            case (mode)
                MODE_HALF:    return x < 0 ? 0 : x;
                MODE_FULL:    return clamp(x < 0 ? -x : x, SAMPLE_MIN, SAMPLE_MAX);
                MODE_SQUARE:  return clamp(round_shift(x * x, 23), SAMPLE_MIN, SAMPLE_MAX);
                MODE_LOWPASS: return biquad(x < 0 ? 0 : x, base, keep);
                default:      return x;
            endcase
        endfunction

        function void note_word(logic [CHANNEL_W-1:0] ch, logic signed [SAMPLE_W-1:0] l,
                                logic signed [SAMPLE_W-1:0] r);
            sample_word_t w;
            int           base;
            bit           keep;
            keep      = int'(ch) < N_CHANNELS;
            base      = keep ? int'(ch) * 4 : 0;
            w.channel = ch;
            w.left    = SAMPLE_W'(treat(longint'(l), base, keep));
            w.right   = SAMPLE_W'(treat(longint'(r), base + 2, keep));
            expected_words.insert(expected_words.size(), w);
            accepted++;
        endfunction

        function void check_word(sample_word_t got);
            sample_word_t want;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, channel %0d left %0d right %0d",
                         $time, got.channel, got.left, got.right);
                mismatches++;
                return;
            end
            want = expected_words.pop_front();
            checked++;
            if (got.channel !== want.channel)
            begin
                $display("%0t: channel_out expected %0d, actual %0d",
                         $time, want.channel, got.channel);
                mismatches++;
            end
            if (got.left !== want.left)
            begin
                $display("%0t: left_out (channel %0d) expected %0d, actual %0d",
                         $time, want.channel, want.left, got.left);
                mismatches++;
            end
            if (got.right !== want.right)
            begin
                $display("%0t: right_out (channel %0d) expected %0d, actual %0d",
                         $time, want.channel, want.right, got.right);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, block and channels
    // ------------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    hcrl_in_if  in_if();
    hcrl_out_if out_if();

    envelope_scoreboard score = new();

    int burst_left   = 0;       // words left in the current input burst
    bit hold_request = 1'b0;    // asks the output side for one long hold-off

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    hair_cell_rectify_lowpass_core #(
        .CHANNELS (N_CHANNELS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_if),
        .out_word  (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one register write; the enable drops for a cycle so back-to-back writes
    // never lower and raise it in the same step
    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge clk);
        score.write_reg(index, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_coefs(logic [CFG_W-1:0] b0, logic [CFG_W-1:0] b1,
                              logic [CFG_W-1:0] b2, logic [CFG_W-1:0] a1,
                              logic [CFG_W-1:0] a2);
        write_reg(REG_B0, b0);
        write_reg(REG_B1, b1);
        write_reg(REG_B2, b2);
        write_reg(REG_A1, a1);
        write_reg(REG_A2, a2);
    endtask

    // offer one word and hold it until taken; a random gap opens each burst,
    // and a quarter of bursts open with no gap so long unbroken runs happen too
    task automatic send_word(logic [CHANNEL_W-1:0] ch, logic signed [SAMPLE_W-1:0] l,
                             logic signed [SAMPLE_W-1:0] r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_if.valid    <= 1'b1;
        in_if.channel  <= ch;
        in_if.left_in  <= l;
        in_if.right_in <= r;
        do
            @(posedge clk);
        while (in_if.ready !== 1'b1);
        burst_left--;
        score.note_word(ch, l, r);
    endtask

    // extremes and small values weighted up, the rest full-range noise
    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            3:       return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // optional directed extremes, then random words, then drain and settle
    task automatic run_words(int n_random, bit directed);
        int                   rr;
        int                   n_active;
        logic [CHANNEL_W-1:0] ch;
        if (directed)
        begin
            // full-scale both ways, zero against minus one, near-full step
            send_word('0, SAMPLE_MAX, SAMPLE_MIN);
            send_word(CHANNEL_W'(N_CHANNELS - 1), SAMPLE_MIN, SAMPLE_MAX);
            send_word('0, '0, -24'sd1);
            send_word(CHANNEL_W'(N_CHANNELS - 1), 24'sd1, SAMPLE_MAX - 24'sd1);
        end
        // in lowpass mode most words sweep a filterbank of random size in
        // order, so each channel's history gets a proper signal through it
        n_active = $urandom_range(1, N_CHANNELS);
        rr       = 0;
        repeat (n_random)
        begin
            if (score.mode == MODE_LOWPASS && $urandom_range(0, 4) != 0)
            begin
                ch = CHANNEL_W'(rr);
                rr = (rr + 1) % n_active;
            end
            else
                ch = CHANNEL_W'($urandom);
            send_word(ch, random_sample(), random_sample());
        end
        in_if.valid <= 1'b0;
        while (score.expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // output side: stall pattern of its own, switching style every so often,
    // plus one long hold-off on request so the block backs up into its input
    // ------------------------------------------------------------------------
    initial
    begin : output_side
        int hold_left;
        int style_left;
        int style;
        int tick;
        bit rdy;
        hold_left  = 0;
        style_left = 0;
        style      = 0;
        tick       = 0;
        out_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (style_left == 0)
            begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(20, 120);
            end
            style_left--;
            tick++;
            if (hold_left != 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                rdy          = 1'b0;
            end
            else
            begin
                case (style)
                    0:       rdy = 1'b1;                          // always taking
                    1:       rdy = ($urandom_range(0, 3) != 0);   // light stalls
                    2:       rdy = (tick % 7) < 3;                // fixed 3 of 7
                    default: rdy = ($urandom_range(0, 1) == 1);   // heavy stalls
                endcase
            end
            out_if.ready <= rdy;
        end
    end

    // every taken output word goes to the checker, values as before the edge
    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
            score.check_word('{out_if.channel_out, out_if.left_out, out_if.right_out});
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin : sequence_main
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_MODE;
        cfg_wdata      <= '0;
        in_if.valid    <= 1'b0;
        in_if.channel  <= '0;
        in_if.left_in  <= '0;
        in_if.right_in <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pass-through from reset, then written explicitly
        run_words(30, 1'b1);
        write_reg(REG_MODE, MODE_NONE);
        run_words(30, 1'b0);

        // butterworth-like lowpass set, 1 kHz corner at 16 kHz, plus writes
        // past the register list that must be ignored
        load_coefs(20'd2018, 20'd4036, 20'd2018, -20'sd95304, 20'd37626);
        write_reg(REG_SPARE_LO, CFG_W'($urandom));
        write_reg(REG_SPARE_HI, CFG_W'($urandom));

        write_reg(REG_MODE, MODE_HALF);
        run_words(80, 1'b1);
        write_reg(REG_MODE, MODE_FULL);      // most negative sample saturates
        run_words(80, 1'b1);
        write_reg(REG_MODE, MODE_SQUARE);    // most negative squared saturates
        run_words(80, 1'b1);

        // lowpass with the output held off at the start, input keeps offering
        write_reg(REG_MODE, MODE_LOWPASS);
        hold_request = 1'b1;
        run_words(160, 1'b1);

        // unused mode codes fall back to pass-through
        write_reg(REG_MODE, MODE_SPARE_5);
        run_words(30, 1'b0);
        write_reg(REG_MODE, MODE_SPARE_6);
        run_words(30, 1'b0);
        write_reg(REG_MODE, MODE_SPARE_7);
        run_words(30, 1'b1);

        // extreme coefficients drive y into saturation both ways
        load_coefs(20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h80000, 20'h7FFFF);
        write_reg(REG_MODE, MODE_LOWPASS);
        run_words(60, 1'b0);
        load_coefs(20'h80000, 20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h80000);
        write_reg(REG_MODE, MODE_LOWPASS);
        run_words(50, 1'b0);

        // random coefficients, then a repeated mode write restarts the filters
        load_coefs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                   CFG_W'($urandom), CFG_W'($urandom));
        write_reg(REG_MODE, MODE_LOWPASS);
        run_words(40, 1'b0);
        write_reg(REG_MODE, MODE_LOWPASS);
        run_words(40, 1'b0);

        $display("covered %0d words (%0d checked) through pass-through, both rectifiers,",
                 score.accepted, score.checked);
        $display("squaring, unused modes, four lowpass coefficient sets, %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (score.mismatches == 0 && score.expected_words.size() == 0)
            $display("tb_hair_cell_rectify_lowpass_core OK");
        else
            $display("tb_hair_cell_rectify_lowpass_core NOT OK");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d words outstanding", $time,
                 score.expected_words.size());
        $display("tb_hair_cell_rectify_lowpass_core NOT OK");
        $finish;
    end

endmodule
